// File: rtl/mte_pkg.sv
package mte_pkg;

	localparam int COUNT_BITS = 12;
	localparam int LIMIT_BITS = 12;
	localparam int CMP_W = (COUNT_BITS + 1 > LIMIT_BITS) ? COUNT_BITS + 1 : LIMIT_BITS;

	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(256);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [1:0] SYM_DOT = 2'd0;
	localparam logic [1:0] SYM_DASH = 2'd1;
	localparam logic [1:0] SYM_SPACE = 2'd2;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_UNSUP = 2'd1;
	localparam logic [1:0] STAT_LONG = 2'd2;

	localparam int NUM_CODES = 36;
	localparam int DIGIT_BASE = 26;

	// letters a..z then digits 0..9, bit i is symbol i (0 dot, 1 dash)
	localparam logic [2:0] MORSE_LEN [NUM_CODES] = '{
		3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
		3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
		3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
		3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
	};

	localparam logic [4:0] CODE_BITS [NUM_CODES] = '{
		5'd2, 5'd1, 5'd5, 5'd1, 5'd0, 5'd4, 5'd3, 5'd0, 5'd0, 5'd14,
		5'd5, 5'd2, 5'd3, 5'd1, 5'd7, 5'd6, 5'd11, 5'd2, 5'd0, 5'd1,
		5'd4, 5'd8, 5'd6, 5'd9, 5'd13, 5'd3,
		5'd31, 5'd30, 5'd28, 5'd24, 5'd16, 5'd0, 5'd1, 5'd3, 5'd7, 5'd15
	};

	typedef struct packed {
		logic       supported;
		logic       space;
		logic [2:0] len;
		logic [4:0] bits;
	} lookup_t;

endpackage

// File: rtl/mte_lookup.sv
module mte_lookup
	import mte_pkg::*;
(
	input  logic [7:0] char_code,
	output lookup_t    info
);

	logic [7:0] off_upper;
	logic [7:0] off_lower;
	logic [7:0] off_digit;
	logic       is_upper;
	logic       is_lower;
	logic       is_digit;
	logic       is_space;
	logic [5:0] idx;

	assign is_upper = (char_code >= 8'h41) && (char_code <= 8'h5a);
	assign is_lower = (char_code >= 8'h61) && (char_code <= 8'h7a);
	assign is_digit = (char_code >= 8'h30) && (char_code <= 8'h39);
	assign is_space = (char_code == 8'h20) || ((char_code >= 8'h09) && (char_code <= 8'h0d));

	assign off_upper = char_code - 8'h41;
	assign off_lower = char_code - 8'h61;
	assign off_digit = char_code - 8'h30 + 8'(DIGIT_BASE);

	always_comb begin
		if (is_upper) begin
			idx = off_upper[5:0];
		end else if (is_lower) begin
			idx = off_lower[5:0];
		end else if (is_digit) begin
			idx = off_digit[5:0];
		end else begin
			idx = '0;
		end

		info.supported = is_upper || is_lower || is_digit || is_space;
		info.space = is_space;
		if (is_space) begin
			info.len = 3'd1;
			info.bits = '0;
		end else begin
			info.len = MORSE_LEN[idx];
			info.bits = CODE_BITS[idx];
		end
	end

endmodule

// File: rtl/text_to_morse_encoder.sv
// order: a request is taken in IDLE and checked in CHECK; an error result is registered from
// CHECK once the output is free, the first symbol from the EMIT state that follows
// pacing: a request with n symbols (up to 6), or an error result, is done before the next is taken
// the check state and the symbol shifter with its count step set the pace
// requests of a dropped message are taken in IDLE and give no result
// arst_n clears the count, the drop flag and the sequencer; buffer limit resets to 256
module text_to_morse_encoder
	import mte_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [LIMIT_BITS-1:0] cfg_wdata,  // buffer_limit
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,    // char_code
	input  logic                  s_tlast,    // last_char
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,    // symbol[1:0], zero pad
	output logic                  m_tlast,    // run_end
	output logic [2:0]            m_tuser     // status[1:0], message_end[2]
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CHECK = 2'd1;
	localparam logic [1:0] S_EMIT  = 2'd2;

	logic [1:0]            state_q;
	logic [LIMIT_BITS-1:0] limit_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  aborted_q;
	logic [7:0]            char_q;
	logic                  last_q;
	logic [4:0]            bits_q;
	logic [2:0]            len_left_q;
	logic [2:0]            rem_q;

	logic                  out_valid_q;
	logic [1:0]            out_sym_q;
	logic [1:0]            out_stat_q;
	logic                  out_run_end_q;
	logic                  out_msg_end_q;

	lookup_t               info;
	logic                  out_free;
	logic                  out_load;
	logic [CMP_W-1:0]      need;
	logic                  too_long;
	logic                  sep;

	mte_lookup u_lookup (
		.char_code (char_q),
		.info      (info)
	);

	assign out_free = !out_valid_q || m_tready;
	assign out_load = out_free && (((state_q == S_CHECK) && (!info.supported || too_long))
		|| (state_q == S_EMIT));
	assign need = CMP_W'(count_q) + CMP_W'(info.len) + CMP_W'(1);
	assign too_long = need >= CMP_W'(limit_q);
	assign sep = !last_q && !info.space;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata = {6'd0, out_sym_q};
	assign m_tlast = out_run_end_q;
	assign m_tuser = {out_msg_end_q, out_stat_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_q <= s_tdata;
			last_q <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			aborted_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_sym_q <= SYM_DOT;
			out_stat_q <= STAT_OK;
			out_run_end_q <= 1'b0;
			out_msg_end_q <= 1'b0;
			bits_q <= '0;
			len_left_q <= '0;
			rem_q <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						if (aborted_q) begin
							if (s_tlast) begin
								aborted_q <= 1'b0;
								count_q <= '0;
							end
						end else begin
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (!info.supported || too_long) begin
						if (out_free) begin
							out_sym_q <= SYM_DOT;
							out_stat_q <= info.supported ? STAT_LONG : STAT_UNSUP;
							out_run_end_q <= 1'b1;
							out_msg_end_q <= 1'b1;
							count_q <= '0;
							aborted_q <= !last_q;
							state_q <= S_IDLE;
						end
					end else begin
						bits_q <= info.bits;
						len_left_q <= info.space ? 3'd0 : info.len;
						rem_q <= info.len + {2'd0, sep};
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_stat_q <= STAT_OK;
						out_sym_q <= (len_left_q == 3'd0) ? SYM_SPACE
							: (bits_q[0] ? SYM_DASH : SYM_DOT);
						out_run_end_q <= (rem_q == 3'd1);
						out_msg_end_q <= last_q && (rem_q == 3'd1);
						bits_q <= {1'b0, bits_q[4:1]};
						if (len_left_q != 3'd0) begin
							len_left_q <= len_left_q - 3'd1;
						end
						rem_q <= rem_q - 3'd1;
						if (rem_q == 3'd1) begin
							state_q <= S_IDLE;
						end
						if (rem_q == 3'd1 && last_q) begin
							count_q <= '0;
						end else if (count_q != COUNT_MAX) begin
							count_q <= count_q + COUNT_BITS'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// error results always close the run and the message
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] != STAT_OK) |-> m_tlast && m_tuser[2] && (m_tdata[1:0] == SYM_DOT))
		else $error("error result without run and message end");

	// a dropped message keeps the sequencer parked
	assert property (@(posedge clk) disable iff (!arst_n)
		aborted_q |-> state_q == S_IDLE)
		else $error("sequencer busy while message dropped");

	// emitting always has a symbol left
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> rem_q != 3'd0)
		else $error("emit with nothing left");

	// message end only comes with run end
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tlast)
		else $error("message end without run end");

endmodule
